/* rtl/core/eucm_pkg.sv */
package eucm_pkg;

   localparam int ALPHA_W    = 17;
   localparam int BETA_W     = 24;
   localparam int FOCAL_W    = 32;
   localparam int CENTER_W   = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // quotient bits kept by the divider; quotients above 2^(QUOT_BITS-1) are capped
   localparam int QUOT_BITS  = 51;

   localparam logic [ALPHA_W-1:0]  ALPHA_ONE    = 17'd65536;
   localparam logic [ALPHA_W-1:0]  ALPHA_RST    = 17'd32768;
   localparam logic [BETA_W-1:0]   BETA_RST     = 24'd65536;
   localparam logic [FOCAL_W-1:0]  FOCAL_RST    = 32'd32768000;
   localparam logic [CENTER_W-1:0] CENTER_U_RST = 32'd20971520;
   localparam logic [CENTER_W-1:0] CENTER_V_RST = 32'd15728640;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ALPHA    = 3'd0,
      REG_BETA     = 3'd1,
      REG_FOCAL_U  = 3'd2,
      REG_FOCAL_V  = 3'd3,
      REG_CENTER_U = 3'd4,
      REG_CENTER_V = 3'd5
   } csr_reg_type;

   // side flags carried by each divider lane, u and v
   typedef struct packed {
      logic den_zero;
      logic ovf;
      logic neg;
   } div_side_type;

endpackage

/* rtl/core/eucm_req_if.sv */
interface eucm_req_if #(parameter int COORD_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic signed [COORD_WIDTH-1:0] point_z;

   modport source(output valid, output point_x, output point_y, output point_z,
                  input ready);
   modport sink(input valid, input point_x, input point_y, input point_z,
                output ready);
endinterface

/* rtl/core/eucm_rsp_if.sv */
interface eucm_rsp_if #(parameter int COORD_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] pixel_u;
   logic signed [COORD_WIDTH-1:0] pixel_v;
   logic                          valid_res;
   logic                          saturated;

   modport source(output valid, output pixel_u, output pixel_v, output valid_res,
                  output saturated, input ready);
   modport sink(input valid, input pixel_u, input pixel_v, input valid_res,
                input saturated, output ready);
endinterface

/* rtl/core/eucm_sqrt_cell.sv */
module eucm_sqrt_cell #(
   parameter int QW  = 90,
   parameter int RW  = 45,
   parameter int SBW = 99
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           adv,
   input  logic           in_valid,
   input  logic [QW-1:0]  in_rad,
   input  logic [RW+1:0]  in_rem,
   input  logic [RW-1:0]  in_root,
   input  logic [SBW-1:0] in_side,
   output logic           out_valid,
   output logic [QW-1:0]  out_rad,
   output logic [RW+1:0]  out_rem,
   output logic [RW-1:0]  out_root,
   output logic [SBW-1:0] out_side
);
   logic           valid_ff;
   logic [QW-1:0]  rad_ff, rad_in;
   logic [RW+1:0]  rem_ff, rem_in;
   logic [RW-1:0]  root_ff, root_in;
   logic [SBW-1:0] side_ff;
   logic [RW+3:0]  cur, trial;
   logic           take;

   always_comb begin
      cur     = {in_rem, in_rad[QW-1:QW-2]};
      trial   = {2'b00, in_root, 2'b01};
      take    = (cur >= trial);
      rem_in  = take ? (RW+2)'(cur - trial) : cur[RW+1:0];
      root_in = {in_root[RW-2:0], take};
      rad_in  = {in_rad[QW-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_side  = side_ff;
endmodule

/* rtl/core/eucm_div_cell.sv */
module eucm_div_cell #(
   parameter int DW  = 63,
   parameter int SBW = 3
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           adv,
   input  logic           in_valid,
   input  logic [DW-1:0]  in_rem,
   input  logic [eucm_pkg::QUOT_BITS-1:0] in_num,
   input  logic [DW-1:0]  in_den,
   input  logic [SBW-1:0] in_side,
   output logic           out_valid,
   output logic [DW-1:0]  out_rem,
   output logic [eucm_pkg::QUOT_BITS-1:0] out_num,
   output logic [DW-1:0]  out_den,
   output logic [SBW-1:0] out_side
);
   import eucm_pkg::*;

   logic                 valid_ff;
   logic [DW-1:0]        rem_ff, rem_in, den_ff;
   logic [QUOT_BITS-1:0] num_ff, num_in;
   logic [SBW-1:0]       side_ff;
   logic [DW:0]          cur;
   logic                 ge;

   // numerator bits shift out at the top, quotient bits shift in at the bottom
   always_comb begin
      cur    = {in_rem, in_num[QUOT_BITS-1]};
      ge     = (cur >= {1'b0, in_den});
      rem_in = ge ? DW'(cur - {1'b0, in_den}) : cur[DW-1:0];
      num_in = {in_num[QUOT_BITS-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff  <= rem_in;
         num_ff  <= num_in;
         den_ff  <= in_den;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_side  = side_ff;
endmodule

/* rtl/core/eucm_point_projection.sv */
// Enhanced unified camera model projection, fully pipelined.
// req_chan (sink): one 3D point per beat, signed fixed point with FRAC_BITS
// fraction bits. rsp_chan (source): one pixel per point, in order, with
// valid_res (denominator positive) and saturated (a coordinate was clamped).
// csr_*: write enable, register index and data; registers are alpha, beta,
// focal_u, focal_v, center_u, center_v (index 0..5), other indexes ignored.
// Write them only while no point is in flight.
// Throughput: one point per cycle while the receiver does not stall. RW is
// half the padded radicand width (45 by default). The square root is a chain
// of RW cells, one root bit each; each coordinate then runs through a chain of
// QUOT_BITS restoring divide cells, one quotient bit each.
// Reset clears all valid flags and loads the register defaults.
// When the receiver stalls, the whole pipeline holds; req_chan.ready is high
// whenever the output register is empty or being taken in the same cycle.
module eucm_point_projection #(
   parameter int FRAC_BITS   = 16,
   parameter int COORD_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   eucm_req_if.sink                          req_chan,
   eucm_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  logic [eucm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [eucm_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import eucm_pkg::*;

   localparam int W    = COORD_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int SW   = 2 * W + 1;
   localparam int SP   = (SW + 1) / 2;
   localparam int QW   = 2 * W + 25;
   localparam int QW2  = QW + (QW % 2);
   localparam int RW   = QW2 / 2;
   localparam int PW   = RW + ALPHA_W;
   localparam int ZW   = W + 8 + ALPHA_W;
   localparam int DW   = ((PW > ZW) ? PW : ZW) + 1;
   localparam int MW   = FOCAL_W + W;
   localparam int NW   = MW + F + 8;
   localparam int QB   = QUOT_BITS;
   localparam int HW   = NW - QB;
   localparam int CSH_L = (F >= 16) ? (F - 16) : 0;
   localparam int CSH_R = (F >= 16) ? 0 : (16 - F);
   localparam int CWW  = CENTER_W + CSH_L;
   localparam int CW   = 16 + F;
   localparam int SUMW = ((QB > CW) ? QB : CW) + 2;
   localparam int SBW  = 3 * W + 3;
   localparam logic [QB-1:0] QCAP = {1'b1, {(QB-1){1'b0}}};
   localparam logic signed [SUMW-1:0] SAT_HI = SUMW'((64'sd1 <<< (W - 1)) - 64'sd1);
   localparam logic signed [SUMW-1:0] SAT_LO = -SAT_HI - SUMW'(1);

   // ---------------- configuration ----------------
   logic [ALPHA_W-1:0]  alpha_ff;
   logic [BETA_W-1:0]   beta_ff;
   logic [FOCAL_W-1:0]  focal_u_ff, focal_v_ff;
   logic [CENTER_W-1:0] center_u_ff, center_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff    <= ALPHA_RST;
         beta_ff     <= BETA_RST;
         focal_u_ff  <= FOCAL_RST;
         focal_v_ff  <= FOCAL_RST;
         center_u_ff <= CENTER_U_RST;
         center_v_ff <= CENTER_V_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_ALPHA:    alpha_ff    <= csr_wdata[ALPHA_W-1:0];
            REG_BETA:     beta_ff     <= csr_wdata[BETA_W-1:0];
            REG_FOCAL_U:  focal_u_ff  <= csr_wdata[FOCAL_W-1:0];
            REG_FOCAL_V:  focal_v_ff  <= csr_wdata[FOCAL_W-1:0];
            REG_CENTER_U: center_u_ff <= csr_wdata[CENTER_W-1:0];
            REG_CENTER_V: center_v_ff <= csr_wdata[CENTER_W-1:0];
            default: ;
         endcase
      end
   end

   logic               out_valid_ff;
   logic               adv;

   assign adv            = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // ---------------- stage 1: magnitudes ----------------
   logic         s1_valid_ff;
   logic [W-1:0] s1_mx_ff, s1_my_ff, s1_mz_ff;
   logic         s1_nx_ff, s1_ny_ff, s1_nz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_nx_ff <= req_chan.point_x[W-1];
         s1_ny_ff <= req_chan.point_y[W-1];
         s1_nz_ff <= req_chan.point_z[W-1];
         s1_mx_ff <= req_chan.point_x[W-1] ? W'(-req_chan.point_x) : W'(req_chan.point_x);
         s1_my_ff <= req_chan.point_y[W-1] ? W'(-req_chan.point_y) : W'(req_chan.point_y);
         s1_mz_ff <= req_chan.point_z[W-1] ? W'(-req_chan.point_z) : W'(req_chan.point_z);
      end
   end

   // ---------------- stage 2: squares ----------------
   logic           s2_valid_ff;
   logic [2*W-1:0] s2_xx_ff, s2_yy_ff, s2_zz_ff;
   logic [W-1:0]   s2_mx_ff, s2_my_ff, s2_mz_ff;
   logic           s2_nx_ff, s2_ny_ff, s2_nz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_xx_ff <= (2*W)'(s1_mx_ff) * (2*W)'(s1_mx_ff);
         s2_yy_ff <= (2*W)'(s1_my_ff) * (2*W)'(s1_my_ff);
         s2_zz_ff <= (2*W)'(s1_mz_ff) * (2*W)'(s1_mz_ff);
         s2_mx_ff <= s1_mx_ff;
         s2_my_ff <= s1_my_ff;
         s2_mz_ff <= s1_mz_ff;
         s2_nx_ff <= s1_nx_ff;
         s2_ny_ff <= s1_ny_ff;
         s2_nz_ff <= s1_nz_ff;
      end
   end

   // ---------------- stage 3: x^2 + y^2 ----------------
   logic           s3_valid_ff;
   logic [SW-1:0]  s3_s_ff;
   logic [2*W-1:0] s3_zz_ff;
   logic [SBW-1:0] s3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_s_ff    <= SW'(s2_xx_ff) + SW'(s2_yy_ff);
         s3_zz_ff   <= s2_zz_ff;
         s3_side_ff <= {s2_mx_ff, s2_my_ff, s2_mz_ff, s2_nx_ff, s2_ny_ff, s2_nz_ff};
      end
   end

   // ---------------- stage 4: beta partial products ----------------
   logic                    s4_valid_ff;
   logic [SP+BETA_W-1:0]    s4_plo_ff;
   logic [SW-SP+BETA_W-1:0] s4_phi_ff;
   logic [QW-1:0]           s4_zq_ff;
   logic [SBW-1:0]          s4_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_plo_ff  <= (SP+BETA_W)'(s3_s_ff[SP-1:0]) * (SP+BETA_W)'(beta_ff);
         s4_phi_ff  <= (SW-SP+BETA_W)'(s3_s_ff[SW-1:SP]) * (SW-SP+BETA_W)'(beta_ff);
         s4_zq_ff   <= QW'(s3_zz_ff) << 16;
         s4_side_ff <= s3_side_ff;
      end
   end

   // ---------------- stage 5: radicand ----------------
   logic           s5_valid_ff;
   logic [QW2-1:0] s5_q_ff;
   logic [SBW-1:0] s5_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_q_ff    <= (QW2'(s4_phi_ff) << SP) + QW2'(s4_plo_ff) + QW2'(s4_zq_ff);
         s5_side_ff <= s4_side_ff;
      end
   end

   // ---------------- square root chain ----------------
   logic           sq_valid [RW+1];
   logic [QW2-1:0] sq_rad   [RW+1];
   logic [RW+1:0]  sq_rem   [RW+1];
   logic [RW-1:0]  sq_root  [RW+1];
   logic [SBW-1:0] sq_side  [RW+1];

   assign sq_valid[0] = s5_valid_ff;
   assign sq_rad[0]   = s5_q_ff;
   assign sq_rem[0]   = '0;
   assign sq_root[0]  = '0;
   assign sq_side[0]  = s5_side_ff;

   for (genvar i = 0; i < RW; i++) begin : g_sqrt
      eucm_sqrt_cell #(.QW(QW2), .RW(RW), .SBW(SBW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (sq_valid[i]),
         .in_rad    (sq_rad[i]),
         .in_rem    (sq_rem[i]),
         .in_root   (sq_root[i]),
         .in_side   (sq_side[i]),
         .out_valid (sq_valid[i+1]),
         .out_rad   (sq_rad[i+1]),
         .out_rem   (sq_rem[i+1]),
         .out_root  (sq_root[i+1]),
         .out_side  (sq_side[i+1])
      );
   end

   logic [W-1:0] sq_mx, sq_my, sq_mz;
   logic         sq_nx, sq_ny, sq_nz;
   logic [ALPHA_W-1:0] a_sel, g_sel;

   assign {sq_mx, sq_my, sq_mz, sq_nx, sq_ny, sq_nz} = sq_side[RW];
   assign a_sel = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
   assign g_sel = ALPHA_ONE - a_sel;

   // ---------------- stage A: alpha terms and numerators ----------------
   logic          sa_valid_ff;
   logic [PW-1:0] sa_p_ff;
   logic [ZW-1:0] sa_zt_ff;
   logic [MW-1:0] sa_nu_ff, sa_nv_ff;
   logic          sa_nx_ff, sa_ny_ff, sa_nz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_valid_ff <= 1'b0;
      end else if (adv) begin
         sa_valid_ff <= sq_valid[RW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sa_p_ff  <= PW'(a_sel) * PW'(sq_root[RW]);
         sa_zt_ff <= ZW'(g_sel) * ZW'({sq_mz, 8'd0});
         sa_nu_ff <= MW'(focal_u_ff) * MW'(sq_mx);
         sa_nv_ff <= MW'(focal_v_ff) * MW'(sq_my);
         sa_nx_ff <= sq_nx;
         sa_ny_ff <= sq_ny;
         sa_nz_ff <= sq_nz;
      end
   end

   // ---------------- stage B: denominator ----------------
   logic          sb_valid_ff;
   logic [DW-1:0] sb_d_ff, sb_d_in, p_ext, zt_ext;
   logic [MW-1:0] sb_nu_ff, sb_nv_ff;
   logic          sb_nx_ff, sb_ny_ff;

   always_comb begin
      p_ext  = DW'(sa_p_ff);
      zt_ext = DW'(sa_zt_ff);
      if (!sa_nz_ff) begin
         sb_d_in = p_ext + zt_ext;
      end else if (p_ext > zt_ext) begin
         sb_d_in = p_ext - zt_ext;
      end else begin
         sb_d_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sb_valid_ff <= 1'b0;
      end else if (adv) begin
         sb_valid_ff <= sa_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sb_d_ff  <= sb_d_in;
         sb_nu_ff <= sa_nu_ff;
         sb_nv_ff <= sa_nv_ff;
         sb_nx_ff <= sa_nx_ff;
         sb_ny_ff <= sa_ny_ff;
      end
   end

   // ---------------- stage C: divider setup ----------------
   logic [NW-1:0] num_u, num_v;
   logic [HW-1:0] hi_u, hi_v;

   assign num_u = {sb_nu_ff, (F+8)'(0)};
   assign num_v = {sb_nv_ff, (F+8)'(0)};
   assign hi_u  = num_u[NW-1:QB];
   assign hi_v  = num_v[NW-1:QB];

   logic          sc_valid_ff;
   logic [DW-1:0] sc_d_ff, sc_rem_u_ff, sc_rem_v_ff;
   logic [QB-1:0] sc_num_u_ff, sc_num_v_ff;
   div_side_type  sc_side_u_ff, sc_side_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_valid_ff <= 1'b0;
      end else if (adv) begin
         sc_valid_ff <= sb_valid_ff;
      end
   end

   // a numerator whose top bits already reach d gives a quotient past the cap
   always_ff @(posedge clock) begin
      if (adv) begin
         sc_d_ff               <= sb_d_ff;
         sc_rem_u_ff           <= DW'(hi_u);
         sc_rem_v_ff           <= DW'(hi_v);
         sc_num_u_ff           <= num_u[QB-1:0];
         sc_num_v_ff           <= num_v[QB-1:0];
         sc_side_u_ff.den_zero <= (sb_d_ff == '0);
         sc_side_u_ff.ovf      <= (DW'(hi_u) >= sb_d_ff);
         sc_side_u_ff.neg      <= sb_nx_ff;
         sc_side_v_ff.den_zero <= (sb_d_ff == '0);
         sc_side_v_ff.ovf      <= (DW'(hi_v) >= sb_d_ff);
         sc_side_v_ff.neg      <= sb_ny_ff;
      end
   end

   // ---------------- divider chains ----------------
   logic          du_valid [QB+1];
   logic [DW-1:0] du_rem   [QB+1];
   logic [QB-1:0] du_num   [QB+1];
   logic [DW-1:0] du_den   [QB+1];
   div_side_type  du_side  [QB+1];
   logic          dv_valid [QB+1];
   logic [DW-1:0] dv_rem   [QB+1];
   logic [QB-1:0] dv_num   [QB+1];
   logic [DW-1:0] dv_den   [QB+1];
   div_side_type  dv_side  [QB+1];

   assign du_valid[0] = sc_valid_ff;
   assign du_rem[0]   = sc_rem_u_ff;
   assign du_num[0]   = sc_num_u_ff;
   assign du_den[0]   = sc_d_ff;
   assign du_side[0]  = sc_side_u_ff;
   assign dv_valid[0] = sc_valid_ff;
   assign dv_rem[0]   = sc_rem_v_ff;
   assign dv_num[0]   = sc_num_v_ff;
   assign dv_den[0]   = sc_d_ff;
   assign dv_side[0]  = sc_side_v_ff;

   for (genvar i = 0; i < QB; i++) begin : g_div
      eucm_div_cell #(.DW(DW), .SBW($bits(div_side_type))) u_cell_u (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (du_valid[i]),
         .in_rem    (du_rem[i]),
         .in_num    (du_num[i]),
         .in_den    (du_den[i]),
         .in_side   (du_side[i]),
         .out_valid (du_valid[i+1]),
         .out_rem   (du_rem[i+1]),
         .out_num   (du_num[i+1]),
         .out_den   (du_den[i+1]),
         .out_side  (du_side[i+1])
      );
      eucm_div_cell #(.DW(DW), .SBW($bits(div_side_type))) u_cell_v (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (dv_valid[i]),
         .in_rem    (dv_rem[i]),
         .in_num    (dv_num[i]),
         .in_den    (dv_den[i]),
         .in_side   (dv_side[i]),
         .out_valid (dv_valid[i+1]),
         .out_rem   (dv_rem[i+1]),
         .out_num   (dv_num[i+1]),
         .out_den   (dv_den[i+1]),
         .out_side  (dv_side[i+1])
      );
   end

   // ---------------- output: sign, center, clamp ----------------
   logic [CWW-1:0]         cu_wide, cv_wide;
   logic [CW-1:0]          cu_fix, cv_fix;
   logic [QB-1:0]          qu_cap, qv_cap;
   logic signed [SUMW-1:0] qu_s, qv_s, su, sv;
   logic                   sat_u, sat_v, den_zero;
   logic [W-1:0]           pu_in, pv_in;
   logic                   sat_in;

   always_comb begin
      cu_wide  = CWW'(center_u_ff) << CSH_L;
      cv_wide  = CWW'(center_v_ff) << CSH_L;
      cu_fix   = CW'(cu_wide >> CSH_R);
      cv_fix   = CW'(cv_wide >> CSH_R);
      qu_cap   = (du_side[QB].ovf || du_num[QB] > QCAP) ? QCAP : du_num[QB];
      qv_cap   = (dv_side[QB].ovf || dv_num[QB] > QCAP) ? QCAP : dv_num[QB];
      qu_s     = $signed(SUMW'(qu_cap));
      qv_s     = $signed(SUMW'(qv_cap));
      su       = (du_side[QB].neg ? -qu_s : qu_s) + $signed(SUMW'(cu_fix));
      sv       = (dv_side[QB].neg ? -qv_s : qv_s) + $signed(SUMW'(cv_fix));
      sat_u    = (su > SAT_HI) || (su < SAT_LO);
      sat_v    = (sv > SAT_HI) || (sv < SAT_LO);
      den_zero = du_side[QB].den_zero;
      if (su > SAT_HI) begin
         pu_in = SAT_HI[W-1:0];
      end else if (su < SAT_LO) begin
         pu_in = SAT_LO[W-1:0];
      end else begin
         pu_in = su[W-1:0];
      end
      if (sv > SAT_HI) begin
         pv_in = SAT_HI[W-1:0];
      end else if (sv < SAT_LO) begin
         pv_in = SAT_LO[W-1:0];
      end else begin
         pv_in = sv[W-1:0];
      end
      sat_in = sat_u || sat_v;
      if (den_zero) begin
         pu_in  = '0;
         pv_in  = '0;
         sat_in = 1'b0;
      end
   end

   logic [W-1:0] pu_ff, pv_ff;
   logic         vres_ff, sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= du_valid[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pu_ff   <= pu_in;
         pv_ff   <= pv_in;
         vres_ff <= !den_zero;
         sat_ff  <= sat_in;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.pixel_u   = $signed(pu_ff);
   assign rsp_chan.pixel_v   = $signed(pv_ff);
   assign rsp_chan.valid_res = vres_ff;
   assign rsp_chan.saturated = sat_ff;
endmodule

/* dv/eucm_point_projection_tb.sv */
`timescale 1ns / 100ps

module eucm_point_projection_tb;
   import eucm_pkg::*;

   localparam int CW        = 32;
   localparam int LAT       = 105;
   localparam int STALL_LIM = 4000;
   localparam logic [CSR_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] IDX_SPARE_HI = 3'd7;
   localparam logic [127:0] QUOT_CAP = 128'd1 << (QUOT_BITS - 1);

   typedef struct packed {
      logic signed [CW-1:0] u;
      logic signed [CW-1:0] v;
      logic                 ok;
      logic                 sat;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   eucm_req_if #(.COORD_WIDTH(CW)) req_chan ();
   eucm_rsp_if #(.COORD_WIDTH(CW)) rsp_chan ();

   eucm_point_projection #(.FRAC_BITS(16), .COORD_WIDTH(CW)) u_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // shadow copy of the camera registers
   logic [ALPHA_W-1:0]  cam_alpha = ALPHA_RST;
   logic [BETA_W-1:0]   cam_beta  = BETA_RST;
   logic [FOCAL_W-1:0]  cam_fu    = FOCAL_RST;
   logic [FOCAL_W-1:0]  cam_fv    = FOCAL_RST;
   logic [CENTER_W-1:0] cam_cu    = CENTER_U_RST;
   logic [CENTER_W-1:0] cam_cv    = CENTER_V_RST;

   pixel_type pixel_q[$];
   bit     gaps_on = 1'b1;
   int     n_sent, n_got, n_invalid, n_sat, n_err, idle_cycles;

   function automatic logic [127:0] magnitude_of(logic [CW-1:0] r);
      logic [CW-1:0] m;
      m = r[CW-1] ? -r : r;
      return {96'd0, m};
   endfunction

   function automatic logic [127:0] root_floor(logic [127:0] q);
      logic [127:0] r, t;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         t = r | (128'd1 << i);
         if (t * t <= q) r = t;
      end
      return r;
   endfunction

   function automatic logic signed [CW-1:0] place_coord(logic [FOCAL_W-1:0] focal,
         logic [127:0] mag, logic neg, logic [CENTER_W-1:0] center,
         logic [127:0] den, ref bit sat);
      logic [127:0] quo;
      longint s;
      quo = (({96'd0, focal} * mag) << 24) / den;
      if (quo > QUOT_CAP) quo = QUOT_CAP;
      s = neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
      s += longint'({32'd0, center});
      if (s > 64'sd2147483647) begin
         s = 64'sd2147483647;
         sat = 1'b1;
      end
      if (s < -64'sd2147483648) begin
         s = -64'sd2147483648;
         sat = 1'b1;
      end
      return s[CW-1:0];
   endfunction

   function automatic pixel_type project_point(logic [CW-1:0] x, logic [CW-1:0] y,
                                               logic [CW-1:0] z);
      logic [127:0] mx, my, mz, a, g, rad, rho, p, zt, den;
      pixel_type res;
      bit sat;
      mx = magnitude_of(x);
      my = magnitude_of(y);
      mz = magnitude_of(z);
      a = (cam_alpha > ALPHA_ONE) ? 128'(ALPHA_ONE) : 128'(cam_alpha);
      g = 128'(ALPHA_ONE) - a;
      rad = (mx * mx + my * my) * 128'(cam_beta) + ((mz * mz) << 16);
      rho = root_floor(rad);
      p = a * rho;
      zt = g * (mz << 8);
      if (!z[CW-1]) den = p + zt;
      else if (p > zt) den = p - zt;
      else den = '0;
      res = '0;
      sat = 1'b0;
      if (den != 0) begin
         res.u = place_coord(cam_fu, mx, x[CW-1], cam_cu, den, sat);
         res.v = place_coord(cam_fv, my, y[CW-1], cam_cv, den, sat);
         res.ok = 1'b1;
         res.sat = sat;
      end
      return res;
   endfunction

   task automatic send_point(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.point_x = x;
      req_chan.point_y = y;
      req_chan.point_z = z;
      do @(posedge clock); while (!req_chan.ready);
      pixel_q.push_back(project_point(x, y, z));
      n_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_chan.valid = 1'b0;
      wait (pixel_q.size() == 0);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         REG_ALPHA:    cam_alpha = val[ALPHA_W-1:0];
         REG_BETA:     cam_beta  = val[BETA_W-1:0];
         REG_FOCAL_U:  cam_fu    = val;
         REG_FOCAL_V:  cam_fv    = val;
         REG_CENTER_U: cam_cu    = val;
         REG_CENTER_V: cam_cv    = val;
         default: ;
      endcase
   endtask

   task automatic set_camera(logic [31:0] al, logic [31:0] be, logic [31:0] fu,
                             logic [31:0] fv, logic [31:0] cu, logic [31:0] cv);
      drain();
      write_reg(REG_ALPHA, al);
      write_reg(REG_BETA, be);
      write_reg(REG_FOCAL_U, fu);
      write_reg(REG_FOCAL_V, fv);
      write_reg(REG_CENTER_U, cu);
      write_reg(REG_CENTER_V, cv);
   endtask

   function automatic logic [CW-1:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
         2: return {{16{1'b0}}, 16'($urandom)} - 32'h0000_8000;
         default: return $urandom_range(0, 32'h07ff_ffff) - 32'h0400_0000;
      endcase
   endfunction

   // mostly points in front of the camera, some behind, some fully random
   task automatic random_points(int n);
      logic [CW-1:0] z;
      repeat (n) begin
         case ($urandom_range(0, 9))
            0, 1:    z = $urandom;
            2:       z = -($urandom_range(1, 32'h0400_0000));
            default: z = $urandom_range(1, 32'h0400_0000);
         endcase
         send_point(rand_coord(), rand_coord(), z);
      end
   endtask

   task automatic test_directed_default();
      send_point('0, '0, '0);                                  // d is zero
      send_point(32'h0001_0000, 32'hffff_0000, 32'h0005_0000);
      send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_point(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001);
      send_point('0, '0, 32'hfff0_0000);                       // straight behind
      send_point(32'h7fff_ffff, '0, 32'h0000_0001);            // huge quotient
      send_point('0, 32'h8000_0000, '0);
      send_point(32'h0000_0001, 32'hffff_ffff, 32'hffff_ffff);
      send_point(32'h0100_0000, 32'h0100_0000, 32'hff00_0000); // behind, wide fov
   endtask

   task automatic test_register_extremes();
      // alpha one, alpha above one, alpha zero; beta zero and max
      set_camera(32'(ALPHA_ONE), 32'h00ff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                 32'hffff_ffff, 32'hffff_ffff);
      test_directed_default();
      set_camera(32'h0001_ffff, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
      test_directed_default();
      set_camera(32'd0, 32'd1, 32'h01f4_0000, 32'h0000_0001, 32'h0140_0000,
                 32'h00f0_0000);
      test_directed_default();
      // writes to unused indexes must leave the camera alone
      drain();
      write_reg(IDX_SPARE_LO, 32'hffff_ffff);
      write_reg(IDX_SPARE_HI, 32'h0000_0000);
      test_directed_default();
   endtask

   task automatic test_random_cameras();
      for (int k = 0; k < 5; k++) begin
         set_camera($urandom_range(0, 32'h1ffff), $urandom_range(0, 32'hff_ffff),
                    $urandom, $urandom, $urandom, $urandom);
         random_points(80);
      end
   endtask

   task automatic test_typical_cameras();
      for (int k = 0; k < 3; k++) begin
         set_camera($urandom_range(32768, 65536), $urandom_range(32768, 131072),
                    $urandom_range(32'h00c8_0000, 32'h03e8_0000),
                    $urandom_range(32'h00c8_0000, 32'h03e8_0000),
                    $urandom_range(0, 32'h0400_0000), $urandom_range(0, 32'h0400_0000));
         random_points(100);
      end
   endtask

   // final stretch with both sides running flat out
   task automatic test_full_rate();
      gaps_on = 1'b0;
      random_points(60);
   endtask

   // result side: random stall bursts while gaps are enabled
   int stall_left;
   always @(negedge clock) begin
      if (reset || !gaps_on) begin
         rsp_chan.ready = 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready = 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 5);
         rsp_chan.ready = 1'b0;
      end else begin
         rsp_chan.ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         n_got++;
         if (pixel_q.size() == 0) begin
            n_err++;
            if (n_err <= 10) $display("unexpected pixel beat u=%h v=%h",
                                      rsp_chan.pixel_u, rsp_chan.pixel_v);
         end else begin
            want = pixel_q.pop_front();
            if (!want.ok) n_invalid++;
            if (want.sat) n_sat++;
            if (rsp_chan.pixel_u !== want.u || rsp_chan.pixel_v !== want.v ||
                rsp_chan.valid_res !== want.ok || rsp_chan.saturated !== want.sat) begin
               n_err++;
               if (n_err <= 10)
                  $display("pixel %0d: got u=%h v=%h ok=%b sat=%b, want u=%h v=%h ok=%b sat=%b",
                           n_got, rsp_chan.pixel_u, rsp_chan.pixel_v, rsp_chan.valid_res,
                           rsp_chan.saturated, want.u, want.v, want.ok, want.sat);
            end
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) || reset)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles > STALL_LIM) begin
         $display("FAIL eucm_point_projection");
         $finish;
      end
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.point_x = '0;
      req_chan.point_y = '0;
      req_chan.point_z = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_default();
      test_register_extremes();
      test_random_cameras();
      test_typical_cameras();
      test_full_rate();
      drain();
      repeat (LAT + 20) @(posedge clock);
      $display("Projected %0d points over 12 camera settings; %0d invalid, %0d clamped.",
               n_sent, n_invalid, n_sat);
      if (n_err == 0 && pixel_q.size() == 0) begin
         $display("PASS eucm_point_projection");
      end else begin
         $display("FAIL eucm_point_projection");
      end
      $finish;
   end

endmodule

/* eucm_point_projection.f */
rtl/core/eucm_pkg.sv
rtl/core/eucm_req_if.sv
rtl/core/eucm_rsp_if.sv
rtl/core/eucm_sqrt_cell.sv
rtl/core/eucm_div_cell.sv
rtl/core/eucm_point_projection.sv
dv/eucm_point_projection_tb.sv
